>>> design/scrr_pkg.sv
// package for the sequential cable retract/return block
// types, codes and constants shared by all scrr files; no dependencies
package scrr_pkg;

  localparam int unsigned MAX_CABLES = 16;
  localparam int unsigned LEN_BITS   = 24;
  localparam int unsigned SLOT_W     = $clog2(MAX_CABLES);
  localparam int unsigned PTR_W      = $clog2(MAX_CABLES + 1);
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned RATE_W     = 24;
  localparam int unsigned FRAC_SH    = 16;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_SH;
  localparam logic [PTR_W-1:0]  PTR_MAX  = PTR_W'(MAX_CABLES);

  typedef enum logic {
    OpLoad = 1'b0,
    OpTick = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    PhaseWait    = 2'd0,
    PhaseRetract = 2'd1,
    PhaseReturn  = 2'd2,
    PhaseDone    = 2'd3
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    RegStartTime   = 2'd0,
    RegMinFraction = 2'd1,
    RegRate        = 2'd2,
    RegCableCount  = 2'd3
  } reg_idx_e;

  // configuration as seen by the datapath, already clamped
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [FRAC_W-1:0] min_fraction;
    logic [RATE_W-1:0] rate;
    logic [PTR_W-1:0]  cable_count;
  } cfg_t;

  // input register contents
  typedef struct packed {
    opcode_e             opcode;
    logic [SLOT_W-1:0]   cable_slot;
    logic [LEN_BITS-1:0] rest_length;
    logic [STEP_W-1:0]   time_step;
    logic [LEN_BITS-1:0] delta;
  } stage_t;

endpackage

>>> design/scrr_if.sv
// word channels of the scrr block: input items and result items
// depends on scrr_pkg
interface scrr_in_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [scrr_pkg::SLOT_W-1:0]     cable_slot;
  logic [scrr_pkg::LEN_BITS-1:0]   rest_length;
  logic [scrr_pkg::STEP_W-1:0]     time_step;

  modport source (output valid, opcode, cable_slot, rest_length, time_step, input ready);
  modport sink   (input valid, opcode, cable_slot, rest_length, time_step, output ready);
endinterface

interface scrr_out_if;
  logic                            valid;
  logic                            ready;
  logic                            command_valid;
  logic [scrr_pkg::LEN_BITS-1:0]   commanded_length;
  logic [scrr_pkg::SLOT_W-1:0]     active_cable;
  logic [1:0]                      phase;

  modport source (output valid, command_valid, commanded_length, active_cable, phase,
                  input ready);
  modport sink   (input valid, command_valid, commanded_length, active_cable, phase,
                  output ready);
endinterface

>>> design/sequential_cable_retract_return_top.sv
// top level of the sequential cable retract/return sequencer
// depends on scrr_pkg, scrr_if, scrr_cfg, scrr_in_stage and scrr_core
//
// usage:
// - in_i carries one word per item: opcode 0 loads the initial length of
//   cable_slot from rest_length and restarts the sequence at cable 0 in
//   retract mode; opcode 1 is a tick that adds time_step to elapsed time and
//   reports the current length of the active cable in rest_length
// - out_o gives exactly one word per input word: command_valid and
//   commanded_length (a new length for the active cable), the cable pointer
//   after the step and the phase (wait, retract, return, finished)
// - configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
//   (0 start time, 1 min fraction, 2 rate, 3 cable count); write only
//   while no word is in flight
// - a word accepted into the input register moves on to the result register
//   when the core takes it; rate times step is formed ahead of the input register
// - throughput is one word per cycle while out_o.ready stays high; the rate is set
//   by the single init-times-fraction multiply and compare between the two registers
// - when the receiver stalls the result register holds and the input register
//   fills; in_i.ready drops while both are occupied and out_o.ready is low
// - reset clears elapsed time, pointer and done, sets retract mode and loads
//   the register defaults; the initial length store is not cleared, a cable
//   must be loaded before it is used
module sequential_cable_retract_return_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [scrr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [scrr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  scrr_in_if.sink                           in_i,
  scrr_out_if.source                        out_o
);

  scrr_pkg::cfg_t   cfg;        // clamped configuration
  scrr_pkg::stage_t stage;      // input register contents
  logic             stage_valid;
  logic             take;       // core consumes the registered word

  scrr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  scrr_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .rate_i        (cfg.rate),
    .take_i        (take),
    .stage_valid_o (stage_valid),
    .stage_o       (stage)
  );

  scrr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .stage_valid_i (stage_valid),
    .stage_i       (stage),
    .take_o        (take),
    .out_o         (out_o)
  );

endmodule

>>> design/scrr_cfg.sv
// configuration registers of the scrr block, with clamping of fraction and count
// depends on scrr_pkg
module scrr_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [scrr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [scrr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output scrr_pkg::cfg_t                     cfg_o
);

  logic [scrr_pkg::TIME_W-1:0] start_q;
  logic [scrr_pkg::FRAC_W-1:0] frac_q;
  logic [scrr_pkg::RATE_W-1:0] rate_q;
  logic [scrr_pkg::PTR_W-1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      frac_q  <= scrr_pkg::FRAC_W'(32768);
      rate_q  <= scrr_pkg::RATE_W'(65536);
      count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (scrr_pkg::reg_idx_e'(cfg_index_i))
        scrr_pkg::RegStartTime:   start_q <= cfg_wdata_i[scrr_pkg::TIME_W-1:0];
        scrr_pkg::RegMinFraction: frac_q  <= cfg_wdata_i[scrr_pkg::FRAC_W-1:0];
        scrr_pkg::RegRate:        rate_q  <= cfg_wdata_i[scrr_pkg::RATE_W-1:0];
        scrr_pkg::RegCableCount:  count_q <= cfg_wdata_i[scrr_pkg::PTR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.start_time   = start_q;
    cfg_o.rate         = rate_q;
    cfg_o.min_fraction = (frac_q > scrr_pkg::FRAC_ONE) ? scrr_pkg::FRAC_ONE : frac_q;
    cfg_o.cable_count  = (count_q > scrr_pkg::PTR_MAX) ? scrr_pkg::PTR_MAX : count_q;
  end

endmodule

>>> design/scrr_in_stage.sv
// input register of the scrr block; also forms the per-tick length step
// depends on scrr_pkg and scrr_in_if
module scrr_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  scrr_in_if.sink              in_i,
  input  logic [scrr_pkg::RATE_W-1:0] rate_i,
  input  logic                 take_i,
  output logic                 stage_valid_o,
  output scrr_pkg::stage_t     stage_o
);

  localparam int unsigned PROD_W = scrr_pkg::RATE_W + scrr_pkg::STEP_W;

  logic             valid_q;
  scrr_pkg::stage_t stage_q;
  scrr_pkg::stage_t stage_d;
  logic [PROD_W-1:0] prod;
  logic             accept;

  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  // step length = (rate * time_step) >> 16, fits the length width
  assign prod = PROD_W'(rate_i) * PROD_W'(in_i.time_step);

  always_comb begin
    stage_d.opcode      = scrr_pkg::opcode_e'(in_i.opcode);
    stage_d.cable_slot  = in_i.cable_slot;
    stage_d.rest_length = in_i.rest_length;
    stage_d.time_step   = in_i.time_step;
    stage_d.delta       = prod[scrr_pkg::FRAC_SH +: scrr_pkg::LEN_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_o       = stage_q;

endmodule

>>> design/scrr_core.sv
// sequencing state, initial length store and result register of the scrr block
// depends on scrr_pkg and scrr_out_if
module scrr_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scrr_pkg::cfg_t    cfg_i,
  input  logic              stage_valid_i,
  input  scrr_pkg::stage_t  stage_i,
  output logic              take_o,
  scrr_out_if.source        out_o
);

  localparam int unsigned LW     = scrr_pkg::LEN_BITS;
  localparam int unsigned TPROD_W = scrr_pkg::LEN_BITS + scrr_pkg::FRAC_W;

  logic [LW-1:0] lengths_q [scrr_pkg::MAX_CABLES];

  logic [scrr_pkg::TIME_W-1:0] elapsed_q, elapsed_d;
  logic [scrr_pkg::PTR_W-1:0]  ptr_q, ptr_d, ptr_inc;
  logic                        retr_q, retr_d;
  logic                        done_q, done_d;

  logic                        res_valid_q;
  logic                        cmd_valid_q, cmd_valid_d;
  logic [LW-1:0]               cmd_len_q, cmd_len_d;
  logic [scrr_pkg::SLOT_W-1:0] cable_q, cable_d;
  scrr_pkg::phase_e            phase_q, phase_d;

  logic [scrr_pkg::TIME_W:0]   time_sum;
  logic [LW-1:0]               init_len;
  logic [TPROD_W-1:0]          tprod;
  logic [LW:0]                 target;
  logic [LW:0]                 grown;
  logic                        active;
  logic                        advance;

  assign advance = stage_valid_i && (!res_valid_q || out_o.ready);
  assign take_o  = advance;

  assign time_sum = {1'b0, elapsed_q} + (scrr_pkg::TIME_W + 1)'(stage_i.time_step);
  assign init_len = lengths_q[ptr_q[scrr_pkg::SLOT_W-1:0]];
  assign tprod    = TPROD_W'(init_len) * TPROD_W'(cfg_i.min_fraction);
  assign target   = tprod[scrr_pkg::FRAC_SH +: LW + 1];
  assign grown    = {1'b0, stage_i.rest_length} + {1'b0, stage_i.delta};
  assign ptr_inc  = ptr_q + scrr_pkg::PTR_W'(1);

  always_comb begin
    elapsed_d   = elapsed_q;
    ptr_d       = ptr_q;
    retr_d      = retr_q;
    done_d      = done_q;
    cmd_valid_d = 1'b0;
    cmd_len_d   = '0;
    active      = 1'b0;

    if (stage_i.opcode == scrr_pkg::OpLoad) begin
      ptr_d  = '0;
      retr_d = 1'b1;
      done_d = 1'b0;
    end else begin
      // saturating elapsed time
      elapsed_d = time_sum[scrr_pkg::TIME_W] ? '1 : time_sum[scrr_pkg::TIME_W-1:0];
      active    = (elapsed_d > cfg_i.start_time) && !done_q;
      if (active) begin
        if (cfg_i.cable_count == '0) begin
          ptr_d  = '0;
          done_d = 1'b1;
        end else if (ptr_q >= cfg_i.cable_count) begin
          // pointer past a lowered count closes the pass
          ptr_d  = '0;
          retr_d = 1'b0;
          done_d = !retr_q;
        end else if (retr_q ? ({1'b0, stage_i.rest_length} > target)
                            : (stage_i.rest_length < init_len)) begin
          cmd_valid_d = 1'b1;
          if (retr_q) begin
            cmd_len_d = (stage_i.delta >= stage_i.rest_length) ? '0
                        : stage_i.rest_length - stage_i.delta;
          end else begin
            cmd_len_d = grown[LW] ? '1 : grown[LW-1:0];
          end
        end else if (ptr_inc >= cfg_i.cable_count) begin
          ptr_d  = '0;
          retr_d = 1'b0;
          done_d = !retr_q;
        end else begin
          ptr_d = ptr_inc;
        end
      end
    end

    if (done_d) begin
      phase_d = scrr_pkg::PhaseDone;
    end else if (elapsed_d <= cfg_i.start_time) begin
      phase_d = scrr_pkg::PhaseWait;
    end else if (retr_d) begin
      phase_d = scrr_pkg::PhaseRetract;
    end else begin
      phase_d = scrr_pkg::PhaseReturn;
    end
    cable_d = done_d ? '0 : ptr_d[scrr_pkg::SLOT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      ptr_q       <= '0;
      retr_q      <= 1'b1;
      done_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        elapsed_q <= elapsed_d;
        ptr_q     <= ptr_d;
        retr_q    <= retr_d;
        done_q    <= done_d;
      end
      res_valid_q <= advance || (res_valid_q && !out_o.ready);
    end
  end

  // initial length store, no reset
  always_ff @(posedge clk_i) begin
    if (advance && stage_i.opcode == scrr_pkg::OpLoad) begin
      lengths_q[stage_i.cable_slot] <= stage_i.rest_length;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cmd_valid_q <= cmd_valid_d;
      cmd_len_q   <= cmd_len_d;
      cable_q     <= cable_d;
      phase_q     <= phase_d;
    end
  end

  assign out_o.valid            = res_valid_q;
  assign out_o.command_valid    = cmd_valid_q;
  assign out_o.commanded_length = cmd_len_q;
  assign out_o.active_cable     = cable_q;
  assign out_o.phase            = phase_q;

`ifndef NO_ASSERTIONS
  a_done_ptr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ptr_q == '0)
    else $error("pointer not cleared in finished state");

  a_cmd_in_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && cmd_valid_q) |->
      (phase_q == scrr_pkg::PhaseRetract || phase_q == scrr_pkg::PhaseReturn))
    else $error("length command outside retract or return");

  a_time_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elapsed_q >= $past(elapsed_q))
    else $error("elapsed time went backwards");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= scrr_pkg::PTR_MAX)
    else $error("cable pointer beyond cable store");
`endif

endmodule
